// ===== rtl/u8kd_pkg.sv =====
// Shared types and constants for the UTF-8 key stream decoder.
`default_nettype none

package u8kd_pkg;

  // One input beat: a raw byte or a special key code, with its modifiers.
  typedef struct packed {
    logic [9:0] key_code;
    logic [2:0] key_modifier;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [30:0] code_point;
    logic        is_special;
    logic [2:0]  out_modifier;
    logic        last_of_run;
  } out_item_t;

  // Up to two results produced by one decoded input.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_bundle_t;

  localparam logic [30:0] ReplChar     = 31'h0000_FFFD;
  localparam logic [30:0] SurrogateLo  = 31'h0000_D800;
  localparam logic [30:0] SurrogateHi  = 31'h0000_DFFF;
  localparam logic [9:0]  SpecialBase  = 10'h100;
  localparam logic [5:0]  ContMask     = 6'h3F;

  // Smallest legal value for each sequence length, two to six bytes.
  localparam logic [30:0] MinLen2 = 31'h0000_0080;
  localparam logic [30:0] MinLen3 = 31'h0000_0800;
  localparam logic [30:0] MinLen4 = 31'h0001_0000;
  localparam logic [30:0] MinLen5 = 31'h0020_0000;
  localparam logic [30:0] MinLen6 = 31'h0400_0000;

endpackage : u8kd_pkg

`default_nettype wire

// ===== rtl/u8kd_decode.sv =====
// Decode core: sequence state registers and the single-pass decode of one byte.
`default_nettype none

module u8kd_decode
  import u8kd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic        mode_i,
  input  wire in_item_t    item_i,
  output res_bundle_t      res_o
);

  logic [30:0] acc_q, acc_d;
  logic [2:0]  rem_q, rem_d;
  logic [30:0] min_q, min_d;
  logic [2:0]  pmod_q, pmod_d;

  logic [9:0]  key;
  logic [2:0]  kmod;
  logic        pending;
  logic        is_cont;
  logic        is_start;
  logic [30:0] acc_shift;
  logic [2:0]  rem_dec;
  logic [30:0] done_val;
  out_item_t   new_res;
  logic        new_emits;

  assign key       = item_i.key_code;
  assign kmod      = item_i.key_modifier;
  assign pending   = (rem_q != 3'd0);
  assign is_cont   = mode_i && (key[9:6] == 4'b0010);
  assign is_start  = (key[9:6] == 4'b0011) && (key[7:1] != 7'h7F);
  assign acc_shift = {acc_q[24:0], key[5:0] & ContMask};
  assign rem_dec   = rem_q - 3'd1;

  // A finished value that is overlong or a surrogate is replaced.
  always_comb begin
    if ((acc_shift < min_q) || ((acc_shift >= SurrogateLo) && (acc_shift <= SurrogateHi))) begin
      done_val = ReplChar;
    end else begin
      done_val = acc_shift;
    end
  end

  // Result of the byte taken as the start of something new.
  always_comb begin
    new_res   = '0;
    new_emits = 1'b1;
    new_res.last_of_run  = 1'b1;
    new_res.out_modifier = kmod;
    if (key >= SpecialBase) begin
      new_res.code_point = {21'd0, key};
      new_res.is_special = 1'b1;
    end else if (!key[7] || !mode_i) begin
      new_res.code_point = {21'd0, key};
    end else if (is_start) begin
      new_emits = 1'b0;
    end else begin
      new_res.code_point = ReplChar;
    end
  end

  // Next state and the results for this beat.
  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    min_d  = min_q;
    pmod_d = pmod_q;
    res_o  = '0;
    if (pending && is_cont) begin
      acc_d = acc_shift;
      rem_d = rem_dec;
      if (rem_dec == 3'd0) begin
        res_o.count              = 2'd1;
        res_o.first.code_point   = done_val;
        res_o.first.out_modifier = pmod_q;
        res_o.first.last_of_run  = 1'b1;
      end
    end else begin
      rem_d = 3'd0;
      // A start byte in decoding mode opens a new sequence.
      if (is_start && mode_i && (key < SpecialBase)) begin
        pmod_d = kmod;
        priority if (!key[5]) begin
          acc_d = {26'd0, key[4:0]};
          min_d = MinLen2;
          rem_d = 3'd1;
        end else if (!key[4]) begin
          acc_d = {27'd0, key[3:0]};
          min_d = MinLen3;
          rem_d = 3'd2;
        end else if (!key[3]) begin
          acc_d = {28'd0, key[2:0]};
          min_d = MinLen4;
          rem_d = 3'd3;
        end else if (!key[2]) begin
          acc_d = {29'd0, key[1:0]};
          min_d = MinLen5;
          rem_d = 3'd4;
        end else begin
          acc_d = {30'd0, key[0]};
          min_d = MinLen6;
          rem_d = 3'd5;
        end
      end
      if (pending) begin
        // The pending sequence was cut short: replacement first.
        res_o.first.code_point   = ReplChar;
        res_o.first.out_modifier = pmod_q;
        res_o.first.last_of_run  = !new_emits;
        res_o.second             = new_res;
        res_o.count              = new_emits ? 2'd2 : 2'd1;
      end else begin
        res_o.first = new_res;
        res_o.count = new_emits ? 2'd1 : 2'd0;
      end
    end
    if (!fire_i) begin
      acc_d       = acc_q;
      rem_d       = rem_q;
      min_d       = min_q;
      pmod_d      = pmod_q;
      res_o.count = 2'd0;
    end
  end

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      min_q  <= '0;
      pmod_q <= '0;
    end else begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      min_q  <= min_d;
      pmod_q <= pmod_d;
    end
  end

endmodule : u8kd_decode

`default_nettype wire

// ===== rtl/u8kd_out_fifo.sv =====
// Four-entry queue: takes up to two beats, gives one per cycle unless stalled.
`default_nettype none

module u8kd_out_fifo
  import u8kd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire res_bundle_t push_i,
  output logic             room2_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_o
);

  out_item_t  mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] wr_nxt;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room2_o     = (cnt_q < 3'd3);
  assign wr_nxt      = wr_q + 2'd1;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q + push_i.count;
    rd_d  = pop ? (rd_q + 2'd1) : rd_q;
    cnt_d = cnt_q + {1'b0, push_i.count} - {2'd0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nxt] <= push_i.second;
    end
  end

endmodule : u8kd_out_fifo

`default_nettype wire

// ===== rtl/utf8_key_stream_decoder.sv =====
// Top level of the UTF-8 key stream decoder: input register, decode core, result queue.
// A beat passes the input register, then the result queue, before its first result appears.
// Throughput: one input beat per cycle unless stalled; two results of a beat are queued together.
// The input register advances only while the four-entry result queue has room for two beats.
// Reset clears all sequence state, empties the queue and sets mode_q to 1.
`default_nettype none

module utf8_key_stream_decoder
  import u8kd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_o
);

  logic        mode_q;
  logic        in_vld_q, in_vld_d;
  in_item_t    in_q;
  logic        room2;
  logic        advance;
  logic        accept;
  res_bundle_t res;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && room2;
  assign in_stall_o  = in_vld_q && !room2;
  assign accept      = in_valid_i && !in_stall_o;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // Input register.
  always_comb begin
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  u8kd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .mode_i (mode_q),
    .item_i (in_q),
    .res_o  (res)
  );

  u8kd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule : utf8_key_stream_decoder

`default_nettype wire
